[sv/lcpbe_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcpbe_pkg
// Shared types and constants of the LED chain PWM bit encoder.
// ----------------------------------------------------------------------------
package lcpbe_pkg;

  localparam int unsigned LED_NUM_DEF   = 4;
  localparam int unsigned BITS_PER_LED  = 24;
  localparam int unsigned BIT_IDX_W     = 5;
  localparam int unsigned COLOR_W       = 24;
  localparam int unsigned DUTY_W        = 16;
  localparam int unsigned SLOTS_W       = 8;
  localparam int unsigned IDX_W         = 8;
  localparam int unsigned ACTION_W      = 2;
  localparam int unsigned IN_TDATA_W    = 32;
  localparam int unsigned OUT_TDATA_W   = 24;
  localparam int unsigned CFG_INDEX_W   = 8;
  localparam int unsigned CFG_DATA_W    = 16;

  localparam logic [DUTY_W-1:0]  DUTY_ONE_RST    = 16'd38;
  localparam logic [DUTY_W-1:0]  DUTY_ZERO_RST   = 16'd82;
  localparam logic [DUTY_W-1:0]  DUTY_LATCH_RST  = 16'd0;
  localparam logic [SLOTS_W-1:0] LATCH_SLOTS_RST = 8'd40;

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET    = 2'd0,
    ACT_UPDATE = 2'd1,
    ACT_TICK   = 2'd2
  } action_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_DUTY_ONE    = 8'd0,
    CFG_DUTY_ZERO   = 8'd1,
    CFG_DUTY_LATCH  = 8'd2,
    CFG_LATCH_SLOTS = 8'd3
  } cfg_reg_e;

endpackage
`default_nettype wire

[sv/led_chain_pwm_bit_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// led_chain_pwm_bit_encoder
// Colour table and per-tick PWM compare value generator for an LED chain.
// ----------------------------------------------------------------------------
// Takes one word per clock unless the output stalls, and returns exactly
// one result word for each via the s1 and output registers. The colour words
// sit in one memory with two entries per LED and a registered read port; a
// set-colour word always writes the entry the running frame does not use, so
// an update takes its snapshot by copying per-LED select and valid bits. The
// single read port serves one tick per cycle unless stalled. An LED never
// written reads as zero. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
module led_chain_pwm_bit_encoder #(
  parameter int unsigned LED_NUM = lcpbe_pkg::LED_NUM_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // led_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  wire  [lcpbe_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // action[1:0]
  input  wire  [lcpbe_pkg::ACTION_W-1:0]       s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire                                  m_axis_tready_i,
  // duty_value[15:0], busy_res[16], update_refused[17], zero[23:18]
  output logic [lcpbe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // frame_last
  output logic                                 m_axis_tlast_o,
  // duty_valid
  output logic                                 m_axis_tuser_o,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [lcpbe_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  wire  [lcpbe_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lcpbe_pkg::*;

  localparam int unsigned LED_W     = (LED_NUM > 1) ? $clog2(LED_NUM) : 1;
  localparam int unsigned MEM_AW    = LED_W + 1;
  localparam int unsigned MEM_DEPTH = 2 * LED_NUM;
  localparam int unsigned SLOTS_MAX = (1 << SLOTS_W) - 1;
  localparam int unsigned POS_W     = $clog2(SLOTS_MAX + BITS_PER_LED * LED_NUM + 1);
  localparam int unsigned K8_W      = POS_W - 3;
  localparam int unsigned RECIP_W   = 10;
  localparam int unsigned RECIP_SH  = 11;
  localparam int unsigned PROD_W    = K8_W + RECIP_W;
  localparam int unsigned QUO_W     = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0]   RECIP_3    = 10'd683;
  localparam logic [POS_W-1:0]     FRAME_BITS = POS_W'(BITS_PER_LED * LED_NUM);
  localparam logic [QUO_W-1:0]     LED_CNT    = QUO_W'(LED_NUM);
  localparam logic [BIT_IDX_W-1:0] BIT_TOP    = BIT_IDX_W'(BITS_PER_LED - 1);

  typedef struct packed {
    logic                 duty_valid;
    logic                 is_bit;
    logic                 snap_ok;
    logic [BIT_IDX_W-1:0] bit_idx;
    logic                 last;
    logic                 busy;
    logic                 refused;
  } s1_t;

  // configuration
  logic [DUTY_W-1:0]  duty_one_q, duty_zero_q, duty_latch_q;
  logic [SLOTS_W-1:0] latch_slots_q;

  // colour store
  logic [COLOR_W-1:0] mem [MEM_DEPTH];
  logic [COLOR_W-1:0] rd_q;
  logic [LED_NUM-1:0] tbl_sel_q, tbl_sel_d, tbl_vld_q, tbl_vld_d;
  logic [LED_NUM-1:0] snap_sel_q, snap_sel_d, snap_vld_q, snap_vld_d;

  // frame position
  logic                 sending_q, sending_d;
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [POS_W-1:0]     pos_inc, pos_k, slots_ext, frame_total, led_base;
  logic [PROD_W-1:0]    quo_prod;
  logic [QUO_W-1:0]     led_sel;
  logic [LED_W-1:0]     rd_led;
  logic [BIT_IDX_W-1:0] bit_rem;
  logic                 led_ok;

  // pipeline
  logic s1_vld_q;
  s1_t  s1_q, s1_d;
  logic o_vld_q;
  logic [OUT_TDATA_W-1:0] o_data_q;
  logic o_last_q, o_user_q;

  action_e            act;
  logic [IDX_W-1:0]   in_idx;
  logic [COLOR_W-1:0] in_word;
  logic               in_acc, o_load, idx_ok, set_en, tick_en, in_latch;
  logic [LED_W-1:0]   wr_led;
  logic               wr_slot;
  logic [MEM_AW-1:0]  wr_addr, rd_addr;
  logic [DUTY_W-1:0]  duty_val;

  assign act     = action_e'(s_axis_tuser_i);
  assign in_idx  = s_axis_tdata_i[7:0];
  assign in_word = {s_axis_tdata_i[23:16], s_axis_tdata_i[15:8], s_axis_tdata_i[31:24]};

  assign o_load          = !o_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !s1_vld_q || o_load;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;

  // split the colour slot into LED and bit: divide by 8, then by 3 via reciprocal
  assign slots_ext   = POS_W'(latch_slots_q);
  assign frame_total = slots_ext + FRAME_BITS;
  assign pos_inc     = pos_q + 1'b1;
  assign pos_k       = pos_q - slots_ext;
  assign quo_prod    = PROD_W'(pos_k[POS_W-1:3]) * PROD_W'(RECIP_3);
  assign led_sel     = quo_prod[PROD_W-1:RECIP_SH];
  assign led_base    = POS_W'({led_sel, 4'd0}) + POS_W'({led_sel, 3'd0});
  assign bit_rem     = BIT_IDX_W'(pos_k - led_base);
  assign led_ok      = led_sel < LED_CNT;
  assign rd_led      = led_sel[LED_W-1:0];

  assign idx_ok   = {1'b0, in_idx} < (IDX_W + 1)'(LED_NUM);
  assign wr_led   = in_idx[LED_W-1:0];
  assign wr_slot  = ~snap_sel_q[wr_led];
  assign wr_addr  = {wr_led, wr_slot};
  assign rd_addr  = {rd_led, snap_sel_q[rd_led]};
  assign in_latch = pos_q < slots_ext;
  assign set_en   = in_acc && (act == ACT_SET) && idx_ok;
  assign tick_en  = in_acc && (act == ACT_TICK) && sending_q;

  always_comb begin
    tbl_sel_d  = tbl_sel_q;
    tbl_vld_d  = tbl_vld_q;
    snap_sel_d = snap_sel_q;
    snap_vld_d = snap_vld_q;
    sending_d  = sending_q;
    pos_d      = pos_q;
    s1_d       = '0;
    s1_d.bit_idx = BIT_TOP - bit_rem;
    s1_d.snap_ok = led_ok && snap_vld_q[rd_led];
    case (act)
      ACT_SET: begin
        if (idx_ok) begin
          tbl_sel_d[wr_led] = wr_slot;
          tbl_vld_d[wr_led] = 1'b1;
        end
      end
      ACT_UPDATE: begin
        if (sending_q) begin
          s1_d.refused = 1'b1;
        end else begin
          snap_sel_d = tbl_sel_q;
          snap_vld_d = tbl_vld_q;
          sending_d  = 1'b1;
          pos_d      = '0;
        end
      end
      ACT_TICK: begin
        if (sending_q) begin
          s1_d.duty_valid = 1'b1;
          if (!in_latch) begin
            s1_d.is_bit = 1'b1;
          end
          if (pos_inc >= frame_total) begin
            s1_d.last = 1'b1;
            sending_d = 1'b0;
            pos_d     = '0;
          end else begin
            pos_d = pos_inc;
          end
        end
      end
      default: begin
      end
    endcase
    s1_d.busy = sending_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      duty_one_q    <= DUTY_ONE_RST;
      duty_zero_q   <= DUTY_ZERO_RST;
      duty_latch_q  <= DUTY_LATCH_RST;
      latch_slots_q <= LATCH_SLOTS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DUTY_ONE:    duty_one_q    <= cfg_data_i;
        CFG_DUTY_ZERO:   duty_zero_q   <= cfg_data_i;
        CFG_DUTY_LATCH:  duty_latch_q  <= cfg_data_i;
        CFG_LATCH_SLOTS: latch_slots_q <= cfg_data_i[SLOTS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (set_en) begin
      mem[wr_addr] <= in_word;
    end
    if (tick_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_sel_q  <= '0;
      tbl_vld_q  <= '0;
      snap_sel_q <= '0;
      snap_vld_q <= '0;
      sending_q  <= 1'b0;
      pos_q      <= '0;
    end else if (in_acc) begin
      tbl_sel_q  <= tbl_sel_d;
      tbl_vld_q  <= tbl_vld_d;
      snap_sel_q <= snap_sel_d;
      snap_vld_q <= snap_vld_d;
      sending_q  <= sending_d;
      pos_q      <= pos_d;
    end
  end

  always_comb begin
    duty_val = '0;
    if (s1_q.duty_valid) begin
      if (!s1_q.is_bit) begin
        duty_val = duty_latch_q;
      end else if (s1_q.snap_ok && rd_q[s1_q.bit_idx]) begin
        duty_val = duty_one_q;
      end else begin
        duty_val = duty_zero_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        s1_vld_q <= s_axis_tvalid_i;
      end
      if (o_load) begin
        o_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (o_load && s1_vld_q) begin
      o_data_q <= {6'd0, s1_q.refused, s1_q.busy, duty_val};
      o_last_q <= s1_q.last;
      o_user_q <= s1_q.duty_valid;
    end
  end

  assign m_axis_tvalid_o = o_vld_q;
  assign m_axis_tdata_o  = o_data_q;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tuser_o  = o_user_q;

endmodule
`default_nettype wire

[sv/lcpbe_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcpbe_port_checker
// Port-level checks on the result stream of the LED chain PWM bit encoder.
// ----------------------------------------------------------------------------
module lcpbe_port_checker (
  input wire                                clk_i,
  input wire                                rst_ni,
  input wire                                m_axis_tvalid_o,
  input wire                                m_axis_tready_i,
  input wire [lcpbe_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o,
  input wire                                m_axis_tlast_o,
  input wire                                m_axis_tuser_o
);
  import lcpbe_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word dropped or changed while stalled");

  a_last_is_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("frame end on a word without a compare value");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> !m_axis_tdata_o[16])
    else $error("still busy after the last slot");

  a_refused_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[17] |-> m_axis_tdata_o[16] && !m_axis_tuser_o)
    else $error("update refused while idle");

endmodule

bind led_chain_pwm_bit_encoder lcpbe_port_checker u_lcpbe_port_checker (.*);
`default_nettype wire

[bench/lcpbe_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lcpbe_checker
// Scoreboard for the LED chain PWM bit encoder.
// ----------------------------------------------------------------------------
// Watches the input, result and configuration channels. It keeps its own copy
// of the colour table, frame snapshot, slot counter and registers. It works
// out the result word for every accepted input word and compares each
// accepted result word, field by field, with the oldest pending prediction.
// ----------------------------------------------------------------------------
module lcpbe_checker
  import lcpbe_pkg::*;
#(
  parameter int unsigned LED_NUM = LED_NUM_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_axis_tvalid_i,
  input  wire                    s_axis_tready_i,
  // led_index[7:0], red[15:8], green[23:16], blue[31:24]
  input  wire  [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action[1:0]
  input  wire  [ACTION_W-1:0]    s_axis_tuser_i,
  input  wire                    m_axis_tvalid_i,
  input  wire                    m_axis_tready_i,
  // duty_value[15:0], busy_res[16], update_refused[17], zero[23:18]
  input  wire  [OUT_TDATA_W-1:0] m_axis_tdata_i,
  // frame_last
  input  wire                    m_axis_tlast_i,
  // duty_valid
  input  wire                    m_axis_tuser_i,
  input  wire                    cfg_valid_i,
  input  wire                    cfg_ready_i,
  input  wire  [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire  [CFG_DATA_W-1:0]  cfg_data_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              valid;
    logic              last;
    logic              busy;
    logic              refused;
  } slot_result_t;

  logic [COLOR_W-1:0] colours [LED_NUM];
  logic [COLOR_W-1:0] snap    [LED_NUM];
  int unsigned        slot_pos;
  logic               sending;
  logic [DUTY_W-1:0]  duty_one;
  logic [DUTY_W-1:0]  duty_zero;
  logic [DUTY_W-1:0]  duty_latch;
  logic [SLOTS_W-1:0] latch_slots;

  slot_result_t slot_results_q [$];

  function automatic slot_result_t encode_word(logic [ACTION_W-1:0] act,
                                               logic [IN_TDATA_W-1:0] data);
    slot_result_t       r;
    logic [7:0]         idx;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [COLOR_W-1:0] grb;
    int unsigned        total;
    int unsigned        k;
    int unsigned        led;
    int unsigned        bitpos;
    idx       = data[7:0];
    red       = data[15:8];
    green     = data[23:16];
    blue      = data[31:24];
    r.duty    = '0;
    r.valid   = 1'b0;
    r.last    = 1'b0;
    r.refused = 1'b0;
    case (act)
      ACT_SET: begin
        if (idx < LED_NUM) colours[idx] = {green, red, blue};
      end
      ACT_UPDATE: begin
        if (sending) begin
          r.refused = 1'b1;
        end else begin
          snap     = colours;
          slot_pos = 0;
          sending  = 1'b1;
        end
      end
      ACT_TICK: begin
        if (sending) begin
          total   = latch_slots + BITS_PER_LED * LED_NUM;
          r.valid = 1'b1;
          if (slot_pos < latch_slots) begin
            r.duty = duty_latch;
          end else begin
            k      = slot_pos - latch_slots;
            led    = k / BITS_PER_LED;
            bitpos = BITS_PER_LED - 1 - (k % BITS_PER_LED);
            grb    = (led < LED_NUM) ? snap[led] : '0;
            r.duty = grb[bitpos] ? duty_one : duty_zero;
          end
          if (slot_pos + 1 >= total) begin
            r.last   = 1'b1;
            sending  = 1'b0;
            slot_pos = 0;
          end else begin
            slot_pos = slot_pos + 1;
          end
        end
      end
      default: ;
    endcase
    r.busy = sending;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin : watch
    slot_result_t want;
    if (!rst_ni) begin
      foreach (colours[i]) begin
        colours[i] = '0;
        snap[i]    = '0;
      end
      slot_pos     = 0;
      sending      = 1'b0;
      duty_one     = DUTY_ONE_RST;
      duty_zero    = DUTY_ZERO_RST;
      duty_latch   = DUTY_LATCH_RST;
      latch_slots  = LATCH_SLOTS_RST;
      fail_count_o = 0;
      slot_results_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_DUTY_ONE:    duty_one    = cfg_data_i;
          CFG_DUTY_ZERO:   duty_zero   = cfg_data_i;
          CFG_DUTY_LATCH:  duty_latch  = cfg_data_i;
          CFG_LATCH_SLOTS: latch_slots = cfg_data_i[SLOTS_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        slot_results_q.push_back(encode_word(s_axis_tuser_i, s_axis_tdata_i));
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (slot_results_q.size() == 0) begin
          $error("result word with no prediction pending");
          fail_count_o++;
        end else begin
          want = slot_results_q.pop_front();
          check_field("duty_value", want.duty, m_axis_tdata_i[15:0]);
          check_field("busy_res", want.busy, m_axis_tdata_i[16]);
          check_field("update_refused", want.refused, m_axis_tdata_i[17]);
          check_field("pad", '0, m_axis_tdata_i[OUT_TDATA_W-1:18]);
          check_field("frame_last", want.last, m_axis_tlast_i);
          check_field("duty_valid", want.valid, m_axis_tuser_i);
        end
      end
    end
    pending_o = slot_results_q.size();
  end

endmodule
`default_nettype wire

[bench/tb_led_chain_pwm_bit_encoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb_led_chain_pwm_bit_encoder
// Stimulus and verdict for the LED chain PWM bit encoder.
// ----------------------------------------------------------------------------
// A short directed run covers idle ticks, the unused action code, colour
// extremes, out-of-range indexes, busy updates, colour writes during a frame
// and a register change mid-frame. Four random phases then play frames, some
// cut short, with random colours and noise under different register settings
// and different amounts of sender idling and receiver stalling, including a
// long receiver hold-off and sender pauses that drain all pending results.
// ----------------------------------------------------------------------------
module tb_led_chain_pwm_bit_encoder;
  import lcpbe_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned PHASE_WORDS = 150;
  localparam logic [ACTION_W-1:0]    ACT_NONE   = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 8'hFF;

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid   = 1'b0;
  wire                    s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata    = '0;
  logic [ACTION_W-1:0]    s_axis_tuser    = '0;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready   = 1'b0;
  wire  [OUT_TDATA_W-1:0] m_axis_tdata;
  wire                    m_axis_tlast;
  wire                    m_axis_tuser;
  logic                   cfg_valid       = 1'b0;
  wire                    cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index       = '0;
  logic [CFG_DATA_W-1:0]  cfg_data        = '0;
  int                     fail_count;
  int                     pending;

  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          hold_req   = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  int unsigned cycles     = 0;
  int unsigned sent       = 0;
  int unsigned cur_latch  = LATCH_SLOTS_RST;

  led_chain_pwm_bit_encoder #(
    .LED_NUM(LED_NUM_DEF)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast),
    .m_axis_tuser_o (m_axis_tuser),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  lcpbe_checker #(
    .LED_NUM(LED_NUM_DEF)
  ) u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_i(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_i(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_i (m_axis_tdata),
    .m_axis_tlast_i (m_axis_tlast),
    .m_axis_tuser_i (m_axis_tuser),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_word(input logic [ACTION_W-1:0] act, input logic [7:0] idx,
                           input logic [7:0] red, input logic [7:0] green,
                           input logic [7:0] blue);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {blue, green, red, idx};
    s_axis_tuser  <= act;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sent++;
  endtask

  task automatic send_random(input logic [ACTION_W-1:0] act, input logic [7:0] idx);
    send_word(act, idx, $urandom_range(255), $urandom_range(255), $urandom_range(255));
  endtask

  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    if (idx == CFG_LATCH_SLOTS) cur_latch = val[SLOTS_W-1:0];
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] one,
                           input logic [CFG_DATA_W-1:0] zero,
                           input logic [CFG_DATA_W-1:0] latch,
                           input logic [CFG_DATA_W-1:0] slots);
    write_reg(CFG_DUTY_ONE, one);
    write_reg(CFG_DUTY_ZERO, zero);
    write_reg(CFG_DUTY_LATCH, latch);
    write_reg(CFG_LATCH_SLOTS, slots);
  endtask

  task automatic send_noise();
    case ($urandom_range(3))
      0: send_random(ACT_SET, $urandom_range(255));
      1: send_random(ACT_SET, $urandom_range(LED_NUM_DEF - 1));
      2: send_random(ACT_UPDATE, $urandom_range(255));
      default: send_random(ACT_NONE, $urandom_range(255));
    endcase
  endtask

  // set some colours, start a frame and tick through it with sparse noise
  task automatic play_frame(input bit with_pauses);
    int unsigned frame_len;
    repeat ($urandom_range(4)) begin
      if ($urandom_range(9) == 0) send_random(ACT_SET, $urandom_range(255));
      else send_random(ACT_SET, $urandom_range(LED_NUM_DEF - 1));
    end
    send_random(ACT_UPDATE, $urandom_range(255));
    frame_len = cur_latch + BITS_PER_LED * LED_NUM_DEF;
    if ($urandom_range(9) == 0) frame_len = $urandom_range(frame_len);
    for (int unsigned i = 0; i < frame_len; i++) begin
      if ($urandom_range(19) == 0) send_noise();
      if (with_pauses && $urandom_range(63) == 0) drain();
      send_random(ACT_TICK, $urandom_range(255));
    end
    repeat ($urandom_range(2)) send_random(ACT_TICK, $urandom_range(255));
  endtask

  task automatic run_phase(input int send_idle, input int recv_stall,
                           input bit with_hold, input bit with_pauses);
    int unsigned target;
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    target    = sent + PHASE_WORDS;
    if (with_hold) begin
      @(posedge clk_i);
      hold_req++;
    end
    while (sent < target) play_frame(with_pauses);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_word(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(ACT_NONE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(ACT_SET, 8'd0, 8'h00, 8'hFF, 8'hAA);
    send_word(ACT_SET, 8'd3, 8'hFF, 8'h00, 8'h55);
    send_word(ACT_SET, 8'd1, 8'h81, 8'h7E, 8'h01);
    send_word(ACT_SET, 8'd4, 8'hFF, 8'hFF, 8'hFF);
    send_word(ACT_SET, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(ACT_UPDATE, 8'h00, 8'h00, 8'h00, 8'h00);
    send_word(ACT_UPDATE, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_word(ACT_SET, 8'd2, 8'hFF, 8'hFF, 8'hFF);
    repeat (3) send_word(ACT_TICK, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // drop the latch slots while the frame runs
    configure(16'hFFFF, 16'h0000, 16'h1234, 16'h0000);
    repeat (5) send_word(ACT_TICK, 8'h00, 8'h00, 8'h00, 8'h00);

    configure(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
    run_phase(0, 0, 1'b0, 1'b0);
    configure(16'h0000, 16'hFFFF, 16'h0000, 16'hFF02);
    run_phase(60, 0, 1'b0, 1'b1);
    configure($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
              16'h00FF);
    run_phase(0, 60, 1'b1, 1'b0);
    configure($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
              $urandom_range(1, 6));
    write_reg(CFG_UNUSED, $urandom_range(65535));
    run_phase(21, 21, 1'b0, 1'b1);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
